// ===== design/mlc_pkg.sv =====
// Shared types and constants of the markup line cleaner.
// Holds store sizes, character codes and the command that passes from front to back.
// Depends on nothing; the queue, front end, back end and top use it by scoped names.
package mlc_pkg;

  // Bounds of the buffered link text and digit runs.
  localparam int TextMax   = 32;
  localparam int DigitsMax = 8;

  // Widths derived from the bounds.
  localparam int TextCntW  = $clog2(TextMax + 1);
  localparam int DigitCntW = $clog2(DigitsMax + 1);
  localparam int TextAW    = (TextMax > 1) ? $clog2(TextMax) : 1;
  localparam int DigitAW   = (DigitsMax > 1) ? $clog2(DigitsMax) : 1;
  localparam int SeqCntW   = (TextCntW > DigitCntW) ? TextCntW : DigitCntW;

  // Depth of the command queue between front and back.
  localparam int CmdDepth = 2;

  // Character codes.
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChOpen  = 8'h5B;
  localparam logic [7:0] ChBar   = 8'h7C;
  localparam logic [7:0] ChClose = 8'h5D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // What the back end replays from the stores.
  typedef enum logic [1:0] {
    REP_NONE,    // nothing from the stores
    REP_TEXT,    // '[' followed by the buffered text
    REP_DIGITS,  // '[' text '|' digits
    REP_LINK     // the buffered text alone, a finished link
  } rep_e;

  // One command: everything a single input byte causes, in output order:
  // hashes, store replay, the byte itself, a trailing '['.
  typedef struct packed {
    logic [1:0]           hashes;
    rep_e                 rep;
    logic [TextCntW-1:0]  tcnt;
    logic [DigitCntW-1:0] dcnt;
    logic                 byte_en;
    logic [7:0]           chr;
    logic                 tail;
    logic                 heading;
    logic                 last;
  } cmd_t;

endpackage

// ===== design/mlc_in_if.sv =====
// Input channel of the markup line cleaner: valid, ready and one raw byte.
// No dependencies.
interface mlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_end;

  modport source (output valid, output in_char, output in_end, input ready);
  modport sink   (input valid, input in_char, input in_end, output ready);
endinterface

// ===== design/mlc_out_if.sv =====
// Output channel of the markup line cleaner: valid, ready and one cleaned result.
// No dependencies.
interface mlc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       has_char;
  logic       heading;
  logic       out_end;

  modport source (output valid, output out_char, output has_char, output heading,
                  output out_end, input ready);
  modport sink   (input valid, input out_char, input has_char, input heading,
                  input out_end, output ready);
endinterface

// ===== design/mlc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mlc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AW-1:0]          waddr_i,
  input  logic [Width-1:0]       wdata_i,
  input  logic [AW-1:0]          raddr_i,
  output logic [Width-1:0]       rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== design/mlc_cmd_fifo.sv =====
// Short command queue between the front and back ends of the line cleaner.
// Depends on mlc_pkg for the command type and depth.
module mlc_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mlc_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output mlc_pkg::cmd_t cmd_o,
  output logic          empty_o,
  output logic          full_o
);
  localparam int PW = (mlc_pkg::CmdDepth > 1) ? $clog2(mlc_pkg::CmdDepth) : 1;
  localparam int CW = $clog2(mlc_pkg::CmdDepth + 1);

  mlc_pkg::cmd_t ent_q [mlc_pkg::CmdDepth];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(mlc_pkg::CmdDepth));
  assign cmd_o   = ent_q[rd_ptr_q];

  // Pointer and fill-count update; wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(mlc_pkg::CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(mlc_pkg::CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end
endmodule

// ===== design/mlc_front.sv =====
// Front end of the line cleaner: accepts bytes, tracks the prefix and link parsing,
// fills the text and digit stores and issues one command per byte that produces or ends a block.
// Depends on mlc_pkg and mlc_in_if.
module mlc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mlc_in_if.sink                       in_if_i,
  input  logic                         fifo_full_i,
  input  logic                         drained_i,
  output logic                         push_o,
  output mlc_pkg::cmd_t                cmd_o,
  output logic                         text_we_o,
  output logic [mlc_pkg::TextAW-1:0]   text_waddr_o,
  output logic                         digit_we_o,
  output logic [mlc_pkg::DigitAW-1:0]  digit_waddr_o,
  output logic [7:0]                   wdata_o
);
  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_BODY,
    PH_TEXT,
    PH_DIGITS
  } phase_e;

  phase_e                         ph_q, ph_d;
  logic [1:0]                     hc_q, hc_d;
  logic                           hd_q, hd_d;
  logic [mlc_pkg::TextCntW-1:0]   tc_q, tc_d;
  logic [mlc_pkg::DigitCntW-1:0]  dc_q, dc_d;
  logic                           lock_q, lock_d;
  logic                           accept;
  logic                           body;
  logic [7:0]                     c;
  mlc_pkg::cmd_t                  cmd;

  // A replay command blocks new bytes until the back end has read the stores.
  assign in_if_i.ready = !lock_q && !fifo_full_i;
  assign accept        = in_if_i.valid && in_if_i.ready;
  assign c             = in_if_i.in_char;

  assign text_waddr_o  = tc_q[mlc_pkg::TextAW-1:0];
  assign digit_waddr_o = dc_q[mlc_pkg::DigitAW-1:0];
  assign wdata_o       = c;
  assign cmd_o         = cmd;

  // Classify the byte and build its command.
  always_comb begin
    ph_d        = ph_q;
    hc_d        = hc_q;
    hd_d        = hd_q;
    tc_d        = tc_q;
    dc_d        = dc_q;
    cmd         = '0;
    cmd.rep     = mlc_pkg::REP_NONE;
    cmd.chr     = c;
    cmd.last    = in_if_i.in_end;
    text_we_o   = 1'b0;
    digit_we_o  = 1'b0;
    body        = 1'b0;
    if (accept) begin
      unique case (ph_q)
        PH_PREFIX: begin
          if (c == mlc_pkg::ChHash && hc_q < 2'd3) begin
            hc_d = hc_q + 2'd1;
          end else if (c == mlc_pkg::ChSpace && hc_q != 2'd0) begin
            hd_d = 1'b1;
            hc_d = 2'd0;
            ph_d = PH_BODY;
          end else begin
            cmd.hashes = hc_q;
            hc_d       = 2'd0;
            ph_d       = PH_BODY;
            body       = 1'b1;
          end
        end
        PH_TEXT: begin
          if (c == mlc_pkg::ChBar) begin
            dc_d = '0;
            ph_d = PH_DIGITS;
          end else if (c != mlc_pkg::ChOpen && c != mlc_pkg::ChClose &&
                       tc_q < mlc_pkg::TextMax) begin
            text_we_o = 1'b1;
            tc_d      = tc_q + 1'b1;
          end else begin
            cmd.rep  = mlc_pkg::REP_TEXT;
            cmd.tcnt = tc_q;
            ph_d     = PH_BODY;
            body     = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (c >= mlc_pkg::ChZero && c <= mlc_pkg::ChNine &&
              dc_q < mlc_pkg::DigitsMax) begin
            digit_we_o = 1'b1;
            dc_d       = dc_q + 1'b1;
          end else if (c == mlc_pkg::ChClose && dc_q != '0) begin
            cmd.rep  = mlc_pkg::REP_LINK;
            cmd.tcnt = tc_q;
            ph_d     = PH_BODY;
          end else begin
            cmd.rep  = mlc_pkg::REP_DIGITS;
            cmd.tcnt = tc_q;
            cmd.dcnt = dc_q;
            ph_d     = PH_BODY;
            body     = 1'b1;
          end
        end
        default: begin
          body = 1'b1;
        end
      endcase

      // Ordinary body byte: a '[' opens an attempt, anything else passes.
      if (body) begin
        if (c == mlc_pkg::ChOpen) begin
          ph_d = PH_TEXT;
          tc_d = '0;
          dc_d = '0;
        end else begin
          cmd.byte_en = 1'b1;
        end
      end

      cmd.heading = hd_d;

      // End of block: flush what is still buffered, then start over.
      if (in_if_i.in_end) begin
        unique case (ph_d)
          PH_PREFIX: cmd.hashes = hc_d;
          PH_TEXT: begin
            if (cmd.rep != mlc_pkg::REP_NONE) begin
              cmd.tail = 1'b1;
            end else begin
              cmd.rep  = mlc_pkg::REP_TEXT;
              cmd.tcnt = tc_d;
            end
          end
          PH_DIGITS: begin
            cmd.rep  = mlc_pkg::REP_DIGITS;
            cmd.tcnt = tc_d;
            cmd.dcnt = dc_d;
          end
          default: begin
          end
        endcase
        ph_d = PH_PREFIX;
        hc_d = 2'd0;
        hd_d = 1'b0;
        tc_d = '0;
        dc_d = '0;
      end
    end
  end

  // Only bytes that produce something, or end the block, enter the queue.
  assign push_o = accept && (cmd.hashes != 2'd0 || cmd.rep != mlc_pkg::REP_NONE ||
                             cmd.byte_en || cmd.tail || cmd.last);

  // Store lock: set by a replay command, released once the back end is drained.
  always_comb begin
    lock_d = lock_q;
    if (push_o && cmd.rep != mlc_pkg::REP_NONE) begin
      lock_d = 1'b1;
    end else if (lock_q && drained_i) begin
      lock_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_PREFIX;
      hc_q   <= 2'd0;
      hd_q   <= 1'b0;
      tc_q   <= '0;
      dc_q   <= '0;
      lock_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      hc_q   <= hc_d;
      hd_q   <= hd_d;
      tc_q   <= tc_d;
      dc_q   <= dc_d;
      lock_q <= lock_d;
    end
  end
endmodule

// ===== design/mlc_back.sv =====
// Back end of the line cleaner: runs queued commands one result at a time,
// reading the stores for replays, and holds the output register.
// Depends on mlc_pkg and mlc_out_if.
module mlc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  mlc_pkg::cmd_t                cmd_i,
  output logic                         pop_o,
  output logic                         idle_o,
  output logic [mlc_pkg::TextAW-1:0]   text_raddr_o,
  input  logic [7:0]                   text_rdata_i,
  output logic [mlc_pkg::DigitAW-1:0]  digit_raddr_o,
  input  logic [7:0]                   digit_rdata_i,
  mlc_out_if.source                    out_if_o
);
  localparam int CW = mlc_pkg::SeqCntW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_OPEN,
    ST_TRD,
    ST_TOUT,
    ST_BAR,
    ST_DRD,
    ST_DOUT,
    ST_BYTE,
    ST_TAIL,
    ST_BARE
  } st_e;

  st_e           state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  mlc_pkg::cmd_t cmd_q, cmd_d;
  logic          out_vld_q;
  logic [7:0]    out_chr_q;
  logic          out_has_q, out_hd_q, out_end_q;

  logic          can_emit, emit, e_has, e_end;
  logic [7:0]    e_chr;
  logic [2:0]    seg_k;
  st_e           nx;
  logic [CW:0]   nxt_idx, tc_ext, dc_ext, hc_ext;

  // First segment of a command at or after order position k; the bare end
  // marker only when the command has nothing else to show.
  function automatic st_e first_from(input logic [2:0] k, input mlc_pkg::cmd_t c);
    st_e s;
    logic rpl;
    rpl = (c.rep == mlc_pkg::REP_TEXT) || (c.rep == mlc_pkg::REP_DIGITS);
    if (k <= 3'd0 && c.hashes != 2'd0) begin
      s = ST_HASH;
    end else if (k <= 3'd1 && rpl) begin
      s = ST_OPEN;
    end else if (k <= 3'd2 && c.rep != mlc_pkg::REP_NONE && c.tcnt != '0) begin
      s = ST_TRD;
    end else if (k <= 3'd3 && c.rep == mlc_pkg::REP_DIGITS) begin
      s = ST_BAR;
    end else if (k <= 3'd4 && c.rep == mlc_pkg::REP_DIGITS && c.dcnt != '0) begin
      s = ST_DRD;
    end else if (k <= 3'd5 && c.byte_en) begin
      s = ST_BYTE;
    end else if (k <= 3'd6 && c.tail) begin
      s = ST_TAIL;
    end else if (k == 3'd0 && c.last) begin
      s = ST_BARE;
    end else begin
      s = ST_IDLE;
    end
    return s;
  endfunction

  assign can_emit      = !out_vld_q || out_if_o.ready;
  assign idle_o        = (state_q == ST_IDLE);
  assign text_raddr_o  = cnt_q[mlc_pkg::TextAW-1:0];
  assign digit_raddr_o = cnt_q[mlc_pkg::DigitAW-1:0];
  assign nxt_idx       = {1'b0, cnt_q} + 1'b1;
  assign tc_ext        = (CW+1)'(cmd_q.tcnt);
  assign dc_ext        = (CW+1)'(cmd_q.dcnt);
  assign hc_ext        = (CW+1)'(cmd_q.hashes);

  // Order position that follows the current segment.
  always_comb begin
    unique case (state_q)
      ST_HASH: seg_k = 3'd1;
      ST_OPEN: seg_k = 3'd2;
      ST_TOUT: seg_k = 3'd3;
      ST_BAR:  seg_k = 3'd4;
      ST_DOUT: seg_k = 3'd5;
      ST_BYTE: seg_k = 3'd6;
      default: seg_k = 3'd7;
    endcase
  end

  assign nx = first_from(seg_k, cmd_q);

  // Sequencer: one result per emitting state, stored bytes pass through a read state first.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_d   = cmd_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    e_chr   = 8'h00;
    e_has   = 1'b1;
    e_end   = cmd_q.last && (nx == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          state_d = first_from(3'd0, cmd_i);
          cnt_d   = '0;
        end
      end
      ST_HASH: begin
        if (can_emit) begin
          emit  = 1'b1;
          e_chr = mlc_pkg::ChHash;
          if (nxt_idx < hc_ext) begin
            e_end = 1'b0;
            cnt_d = nxt_idx[CW-1:0];
          end else begin
            state_d = nx;
            cnt_d   = '0;
          end
        end
      end
      ST_OPEN, ST_TAIL: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_chr   = mlc_pkg::ChOpen;
          state_d = nx;
          cnt_d   = '0;
        end
      end
      ST_BAR: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_chr   = mlc_pkg::ChBar;
          state_d = nx;
          cnt_d   = '0;
        end
      end
      ST_BYTE: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_chr   = cmd_q.chr;
          state_d = nx;
          cnt_d   = '0;
        end
      end
      ST_TRD: state_d = ST_TOUT;
      ST_DRD: state_d = ST_DOUT;
      ST_TOUT: begin
        if (can_emit) begin
          emit  = 1'b1;
          e_chr = text_rdata_i;
          if (nxt_idx < tc_ext) begin
            e_end   = 1'b0;
            cnt_d   = nxt_idx[CW-1:0];
            state_d = ST_TRD;
          end else begin
            state_d = nx;
            cnt_d   = '0;
          end
        end
      end
      ST_DOUT: begin
        if (can_emit) begin
          emit  = 1'b1;
          e_chr = digit_rdata_i;
          if (nxt_idx < dc_ext) begin
            e_end   = 1'b0;
            cnt_d   = nxt_idx[CW-1:0];
            state_d = ST_DRD;
          end else begin
            state_d = nx;
            cnt_d   = '0;
          end
        end
      end
      ST_BARE: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_has   = 1'b0;
          e_end   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_if_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Command and output payload.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (emit) begin
      out_chr_q <= e_chr;
      out_has_q <= e_has;
      out_hd_q  <= cmd_q.heading;
      out_end_q <= e_end;
    end
  end

  assign out_if_o.valid    = out_vld_q;
  assign out_if_o.out_char = out_chr_q;
  assign out_if_o.has_char = out_has_q;
  assign out_if_o.heading  = out_hd_q;
  assign out_if_o.out_end  = out_end_q;

  // A store read is always followed by the cycle that shows its data.
  a_read_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRD) |=> (state_q == ST_TOUT))
    else $error("text read not followed by its output cycle");

  // The bare end marker only closes a block whose last byte produced nothing.
  a_bare_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BARE) |-> (cmd_q.last && !cmd_q.byte_en && cmd_q.hashes == 2'd0))
    else $error("bare end marker for a command that has output");

  // Digits are replayed only by a failed link attempt.
  a_digits_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DOUT) |-> (cmd_q.rep == mlc_pkg::REP_DIGITS))
    else $error("digit replay without a digit command");

  // Text reads stay below the buffered count.
  a_text_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TOUT) |-> ({1'b0, cnt_q} < tc_ext))
    else $error("text read beyond the buffered count");
endmodule

// ===== design/markup_line_cleaner_unit.sv =====
// Markup line cleaner: top level.
// Input channel in_if_i takes one raw byte per request with in_end on the last byte
// of a block. Output channel out_if_o gives one cleaned byte per request, tagged
// with the heading flag; out_end marks the block's final result, and a request with
// has_char low is a bare end marker for a block whose last byte produced nothing.
// A front end parses the heading prefix and links and fills the text and digit
// stores; a two-entry command queue feeds a back end that sequences the results.
// A byte that passes straight through is held in the queue, then in the back end's
// command register, then in the output register. The back end fetches a command only
// in its idle state, after all results of the last one; meanwhile the front end can
// queue new bytes. Replayed or link text passes each stored byte through a store read,
// then an emit; after a byte that replays the stores, input ready stays low until the
// back end has drained the queue. A stalled receiver holds the output register; the
// back end stops, the queue fills and ready on the input drops. Reset clears all control
// state and starts a new block; the store contents are not cleared.
// Depends on mlc_pkg, mlc_in_if, mlc_out_if, mlc_ram, mlc_cmd_fifo, mlc_front, mlc_back.
module markup_line_cleaner_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  mlc_in_if.sink     in_if_i,
  mlc_out_if.source  out_if_o
);
  logic                         push, pop, fifo_empty, fifo_full, back_idle, drained;
  mlc_pkg::cmd_t                cmd_in, cmd_out;
  logic                         text_we, digit_we;
  logic [mlc_pkg::TextAW-1:0]   text_waddr, text_raddr;
  logic [mlc_pkg::DigitAW-1:0]  digit_waddr, digit_raddr;
  logic [7:0]                   wdata, text_rdata, digit_rdata;

  assign drained = fifo_empty && back_idle;

  // Parsing front end.
  mlc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_if_i       (in_if_i),
    .fifo_full_i   (fifo_full),
    .drained_i     (drained),
    .push_o        (push),
    .cmd_o         (cmd_in),
    .text_we_o     (text_we),
    .text_waddr_o  (text_waddr),
    .digit_we_o    (digit_we),
    .digit_waddr_o (digit_waddr),
    .wdata_o       (wdata)
  );

  // Link text and digit stores.
  mlc_ram #(.Width(8), .Depth(mlc_pkg::TextMax)) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (text_we),
    .waddr_i (text_waddr),
    .wdata_i (wdata),
    .raddr_i (text_raddr),
    .rdata_o (text_rdata)
  );

  mlc_ram #(.Width(8), .Depth(mlc_pkg::DigitsMax)) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (digit_we),
    .waddr_i (digit_waddr),
    .wdata_i (wdata),
    .raddr_i (digit_raddr),
    .rdata_o (digit_rdata)
  );

  // Command queue.
  mlc_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  // Result sequencer and output register.
  mlc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!fifo_empty),
    .cmd_i         (cmd_out),
    .pop_o         (pop),
    .idle_o        (back_idle),
    .text_raddr_o  (text_raddr),
    .text_rdata_i  (text_rdata),
    .digit_raddr_o (digit_raddr),
    .digit_rdata_i (digit_rdata),
    .out_if_o      (out_if_o)
  );
endmodule
